// ===== design/kws_pkg.sv =====
// Shared constants and types for the windowed Kalman smoother.
package kws_pkg;

  localparam int MAX_WINDOW_DEF = 128;
  localparam int DATA_W         = 32;
  localparam int DEN_W          = 48;
  localparam int CFG_AW         = 2;
  localparam int CFG_DW         = 32;
  localparam int DIV_STEPS      = 31;

  localparam logic [31:0] ONE_Q31   = 32'h8000_0000;
  localparam logic [31:0] NOISE_RST = 32'd32768;
  localparam logic [7:0]  WIN_RST   = 8'd30;

  typedef enum logic [CFG_AW-1:0] {
    REG_NOISE = 2'd0,
    REG_INIT  = 2'd1,
    REG_WIN   = 2'd2
  } cfg_reg_t;

endpackage

// ===== design/kws_ring.sv =====
// Sample ring memory: one write port, one registered read port.
module kws_ring import kws_pkg::*; #(
  parameter int DEPTH = MAX_WINDOW_DEF,
  parameter int AW    = 7
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/kws_div.sv =====
// Restoring divider for the gain: q = floor(p * 2^31 / den), given p < den.
module kws_div import kws_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [31:0]      p,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [31:0]      q
);

  logic [DEN_W:0]   rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [31:0]      q_r, q_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   sh;

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sh       = {rem_r[DEN_W-1:0], 1'b0};
    if (start) begin
      rem_nxt  = (DEN_W+1)'(p);
      den_nxt  = den;
      q_nxt    = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {1'b0, den_r}) begin
        rem_nxt = sh - {1'b0, den_r};
        q_nxt   = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = sh;
        q_nxt   = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

// ===== design/windowed_kalman_smoother_top.sv =====
// Windowed Kalman smoother: config, sequencer, multiply and update datapath.
// Each item reruns the filter over len window samples; each window step goes
// through read, serial gain division, multiply and update, and no new item is
// accepted until the estimate of the last one has been taken for the output.
// After reset a clearing pass zeroes every ring entry, during which no item is
// accepted; configuration writes are taken at any time.
module windowed_kalman_smoother_top import kws_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [31:0]       in_tdata,   // [31:0] sample
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,  // [31:0] estimate
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LW = $clog2(MAX_WINDOW + 1) > 0 ? $clog2(MAX_WINDOW + 1) : 1;

  typedef enum logic [6:0] {
    S_CLR  = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_READ = 7'b0000100,
    S_DIV  = 7'b0001000,
    S_MUL  = 7'b0010000,
    S_UPD  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  function automatic logic [LW-1:0] clamp_len(input logic [7:0] v);
    if (v == 8'd0) begin
      return LW'(1);
    end else if (int'(v) > MAX_WINDOW) begin
      return LW'(MAX_WINDOW);
    end else begin
      return LW'(v);
    end
  endfunction

  state_t             state_r, state_nxt;
  logic [31:0]        noise_r;
  logic signed [31:0] init_r;
  logic [LW-1:0]      len_r;
  logic [AW-1:0]      wp_r, wp_nxt;
  logic [AW-1:0]      clr_r, clr_nxt;
  logic [AW-1:0]      rd_r, rd_nxt;
  logic [LW-1:0]      cnt_r, cnt_nxt;
  logic [31:0]        p_r, p_nxt;
  logic signed [31:0] est_r, est_nxt;
  logic [62:0]        prod_k_r;
  logic [63:0]        prod_p_r;
  logic               neg_r;
  logic               out_valid_r;
  logic [31:0]        out_data_r;

  logic               in_acc;
  logic [AW-1:0]      wp_use, wp_new;
  logic [LW-1:0]      wp_use_l, wp_inc_l, rd_inc_l;
  logic               ring_we, ring_re;
  logic [AW-1:0]      ring_waddr;
  logic [31:0]        ring_wdata, ring_rdata;
  logic               div_start, div_done;
  logic [31:0]        div_q;
  logic [DEN_W-1:0]   den;
  logic signed [32:0] diff;
  logic [31:0]        mag;
  logic [32:0]        step;
  logic signed [33:0] est_w;
  logic               out_free;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign wp_use   = (LW'(wp_r) >= len_r) ? '0 : wp_r;
  assign wp_use_l = LW'(wp_use);
  assign wp_inc_l = wp_use_l + LW'(1);
  assign wp_new   = (wp_inc_l >= len_r) ? '0 : AW'(wp_inc_l);
  assign rd_inc_l = LW'(rd_r) + LW'(1);

  assign den  = DEN_W'(p_r) + {noise_r, 15'd0};
  assign diff = 33'(signed'(ring_rdata)) - 33'(est_r);
  assign mag  = diff[32] ? 32'(-diff) : 32'(diff);
  assign step = 33'((64'(prod_k_r) + 64'h4000_0000) >> 31);
  assign est_w = neg_r ? (34'(est_r) - 34'(signed'({1'b0, step})))
                       : (34'(est_r) + 34'(signed'({1'b0, step})));

  always_comb begin
    state_nxt  = state_r;
    wp_nxt     = wp_r;
    clr_nxt    = clr_r;
    rd_nxt     = rd_r;
    cnt_nxt    = cnt_r;
    p_nxt      = p_r;
    est_nxt    = est_r;
    ring_we    = 1'b0;
    ring_waddr = wp_use;
    ring_wdata = in_tdata;
    ring_re    = 1'b0;
    div_start  = 1'b0;
    case (state_r)
      S_CLR: begin
        ring_we    = 1'b1;
        ring_waddr = clr_r;
        ring_wdata = '0;
        clr_nxt    = clr_r + AW'(1);
        if (clr_r == AW'(MAX_WINDOW - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          ring_we   = 1'b1;
          wp_nxt    = wp_new;
          rd_nxt    = wp_new;
          cnt_nxt   = '0;
          p_nxt     = ONE_Q31;
          est_nxt   = init_r;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        ring_re   = 1'b1;
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (est_w > 34'sd2147483647) begin
          est_nxt = 32'sh7fff_ffff;
        end else if (est_w < -34'sd2147483648) begin
          est_nxt = 32'sh8000_0000;
        end else begin
          est_nxt = 32'(est_w);
        end
        p_nxt   = 32'(prod_p_r >> 31);
        rd_nxt  = (rd_inc_l >= len_r) ? '0 : AW'(rd_inc_l);
        cnt_nxt = cnt_r + LW'(1);
        if (cnt_r == len_r - LW'(1)) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (cfg_we && cfg_addr == REG_WIN) begin
      wp_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      wp_r        <= '0;
      rd_r        <= '0;
      cnt_r       <= '0;
      noise_r     <= NOISE_RST;
      init_r      <= '0;
      len_r       <= clamp_len(WIN_RST);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      wp_r    <= wp_nxt;
      rd_r    <= rd_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          REG_NOISE: if (cfg_wdata != '0) noise_r <= cfg_wdata;
          REG_INIT:  init_r <= signed'(cfg_wdata);
          REG_WIN:   len_r <= clamp_len(cfg_wdata[7:0]);
          default:   ;
        endcase
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    p_r   <= p_nxt;
    est_r <= est_nxt;
    if (state_r == S_MUL) begin
      prod_k_r <= 63'(mag) * 63'(div_q);
      prod_p_r <= 64'(p_r) * 64'(ONE_Q31 - div_q);
      neg_r    <= diff[32];
    end
    if (state_r == S_DONE && out_free) begin
      out_data_r <= est_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  kws_ring #(.DEPTH(MAX_WINDOW), .AW(AW)) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (ring_wdata),
    .re    (ring_re),
    .raddr (rd_r),
    .rdata (ring_rdata)
  );

  kws_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .p     (p_r),
    .den   (den),
    .done  (div_done),
    .q     (div_q)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_READ)
    else $error("pass did not start after accepted item");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside of division state");

  a_p_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ || state_r == S_MUL) |-> p_r <= ONE_Q31)
    else $error("covariance above one");

  a_cnt_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_UPD |-> cnt_r < len_r)
    else $error("step count past window length");

endmodule
